[rtl/rwcr_pkg.sv]
// Shared types, codes and constants for the recordable wavetable cubic reader.
// No dependencies; the front end, back end and top level refer to this package by scoped names.
package rwcr_pkg;

  localparam int unsigned DefTableDepth = 4096;
  localparam int unsigned DefSampleBits = 16;

  localparam logic signed [15:0] GateOnCode  = 16'sd6554;
  localparam logic signed [15:0] GateOffCode = 16'sd327;

  typedef enum logic [2:0] {
    CfgPhaseRange  = 3'd0,
    CfgOutputRange = 3'd1,
    CfgEdgeMode    = 3'd2,
    CfgRecordMode  = 3'd3,
    CfgTableLength = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RangeBipolar10  = 2'd0,
    RangeBipolar5   = 2'd1,
    RangeUnipolar10 = 2'd2
  } range_e;

  typedef enum logic [1:0] {
    EdgeConstant = 2'd0,
    EdgeMirror   = 2'd1,
    EdgePeriodic = 2'd2
  } edge_e;

  typedef enum logic {
    RecordGate   = 1'b0,
    RecordToggle = 1'b1
  } rec_mode_e;

  typedef struct packed {
    logic [1:0]  phase_range;
    logic [1:0]  output_range;
    logic [1:0]  edge_mode;
    logic        record_mode;
    logic [12:0] table_length;
  } cfg_t;

  localparam logic [1:0]  PhaseRangeReset  = 2'd2;
  localparam logic [1:0]  OutputRangeReset = 2'd0;
  localparam logic [1:0]  EdgeModeReset    = 2'd2;
  localparam logic        RecordModeReset  = 1'b0;
  localparam logic [12:0] TableLengthReset = 13'd10;

  // Map a voltage code onto a Q1.16 table position, clamped to 0..65536.
  function automatic logic [16:0] map_q16(input logic signed [15:0] x,
                                          input logic [1:0] mode);
    logic signed [18:0] p;
    p = 19'sd0;
    case (mode)
      RangeBipolar10: p = 19'(x) + 19'sd32768;
      RangeBipolar5:  p = (19'(x) <<< 1) + 19'sd32768;
      default:        p = 19'(x) <<< 1;
    endcase
    if (p < 19'sd0) begin
      map_q16 = 17'd0;
    end else if (p > 19'sd65536) begin
      map_q16 = 17'h10000;
    end else begin
      map_q16 = p[16:0];
    end
  endfunction

endpackage

[rtl/rwcr_front.sv]
// Front end: accepts requests, qualifies gate and button, resolves table indices.
// Depends on rwcr_pkg.
module rwcr_front #(
  parameter int unsigned TABLE_DEPTH = rwcr_pkg::DefTableDepth,
  parameter int unsigned SAMPLE_BITS = rwcr_pkg::DefSampleBits,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned SW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rwcr_pkg::cfg_t          cfg_i,
  input  logic [SW-1:0]           size_i,
  input  logic                    clearing_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [15:0]      play_position_i,
  input  logic signed [15:0]      record_position_i,
  input  logic signed [15:0]      record_sample_i,
  input  logic signed [15:0]      record_gate_level_i,
  input  logic                    record_button_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output logic                    push_rec_o,
  output logic [AW-1:0]           push_rec_idx_o,
  output logic [SAMPLE_BITS-1:0]  push_entry_o,
  output logic [AW-1:0]           push_play_idx_o,
  output logic [16:0]             push_frac_o
);

  localparam int unsigned S  = SAMPLE_BITS;
  localparam int unsigned PW = 17 + SW;

  logic gate_q, gate_d, button_q, rec_q, rec_d, accept;
  logic [16:0] rp, pp, nn;
  logic [PW-1:0] rprod, pprod;
  logic [SW:0] ridx_raw, pidx_raw;
  logic [AW-1:0] ridx, pidx;
  logic [S+16:0] ntmp;
  logic [S:0] ewide;
  logic [PW-1:0] frac_wide;

  assign in_ready_o   = push_ready_i & ~clearing_i;
  assign push_valid_o = in_valid_i & ~clearing_i;
  assign accept       = push_valid_o & push_ready_i;

  always_comb begin
    gate_d = gate_q;
    if (record_gate_level_i >= rwcr_pkg::GateOnCode) begin
      gate_d = 1'b1;
    end else if (record_gate_level_i <= rwcr_pkg::GateOffCode) begin
      gate_d = 1'b0;
    end
    if (cfg_i.record_mode == rwcr_pkg::RecordGate) begin
      rec_d = gate_d | record_button_i;
    end else begin
      rec_d = rec_q ^ ((gate_d & ~gate_q) | (record_button_i & ~button_q));
    end
  end

  // Record and play positions to clamped table indices, play fraction and record entry.
  always_comb begin
    rp = rwcr_pkg::map_q16(record_position_i, cfg_i.phase_range);
    pp = rwcr_pkg::map_q16(play_position_i, cfg_i.phase_range);
    rprod = PW'(rp) * PW'(size_i);
    pprod = PW'(pp) * PW'(size_i);
    ridx_raw = rprod[PW-1:16];
    pidx_raw = pprod[PW-1:16];
    ridx = (ridx_raw >= {1'b0, size_i}) ? AW'(size_i - SW'(1)) : ridx_raw[AW-1:0];
    pidx = (pidx_raw >= {1'b0, size_i}) ? AW'(size_i - SW'(1)) : pidx_raw[AW-1:0];
    frac_wide = pprod - (PW'(pidx) << 16);
    nn = rwcr_pkg::map_q16(record_sample_i, cfg_i.output_range);
    ntmp = {nn, {S{1'b0}}};
    ewide = ntmp[S+16:16];
  end

  assign push_rec_o      = rec_d;
  assign push_rec_idx_o  = ridx;
  assign push_entry_o    = ewide[S] ? {S{1'b1}} : ewide[S-1:0];
  assign push_play_idx_o = pidx;
  assign push_frac_o     = frac_wide[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q   <= 1'b0;
      button_q <= 1'b0;
      rec_q    <= 1'b0;
    end else if (accept) begin
      gate_q   <= gate_d;
      button_q <= record_button_i;
      rec_q    <= rec_d;
    end
  end

endmodule

[rtl/rwcr_queue.sv]
// Two-entry request queue between front end and back end.
// Depends on nothing but its width parameter.
module rwcr_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] slot_q [2];
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

[rtl/rwcr_back.sv]
// Back end: table memory with clearing pass, record write, four reads and the cubic datapath.
// Depends on rwcr_pkg.
module rwcr_back #(
  parameter int unsigned TABLE_DEPTH = rwcr_pkg::DefTableDepth,
  parameter int unsigned SAMPLE_BITS = rwcr_pkg::DefSampleBits,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned SW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rwcr_pkg::cfg_t          cfg_i,
  input  logic [SW-1:0]           size_i,
  output logic                    clearing_o,
  input  logic                    pop_valid_i,
  output logic                    pop_ready_o,
  input  logic                    pop_rec_i,
  input  logic [AW-1:0]           pop_rec_idx_i,
  input  logic [SAMPLE_BITS-1:0]  pop_entry_i,
  input  logic [AW-1:0]           pop_play_idx_i,
  input  logic [16:0]             pop_frac_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [15:0]      stepped_value_o,
  output logic signed [15:0]      smooth_value_o,
  output logic                    recording_active_o
);

  localparam int unsigned S   = SAMPLE_BITS;
  localparam int unsigned EW  = SW + 2;
  localparam int unsigned IW  = S + 23;
  localparam int unsigned PW  = S + 42;
  localparam int unsigned XW  = PW - 17;
  localparam int unsigned DVW = ((XW + 5) / 4) * 4;
  localparam int unsigned NN  = DVW / 4;
  localparam int unsigned NCW = $clog2(NN + 1);
  localparam int unsigned RFW = XW + 3;
  localparam int unsigned RW  = S + 20;
  localparam int unsigned FW  = S + 39;
  localparam int unsigned YW  = S + 8;
  localparam int unsigned CW  = YW + 17;

  typedef enum logic [3:0] {
    StClear, StIdle, StWrite, StRdA, StRdB, StRdC, StRdD,
    StMul1, StMul2, StSumP, StDiv, StMulR, StFin
  } state_e;

  state_e state_q;
  logic [AW-1:0] clr_cnt_q;
  logic [NCW-1:0] div_cnt_q;
  logic out_valid_q, rec_out_q;
  logic signed [15:0] stepped_q, smooth_q;

  logic [S-1:0] mem [TABLE_DEPTH];
  logic [S-1:0] rd_q;
  logic mem_we;
  logic [AW-1:0] mem_addr;
  logic [S-1:0] mem_wdata;

  logic rec_q;
  logic [AW-1:0] ri_q, ia_q, ib_q, ic_q, id_q;
  logic [S-1:0] entry_q, a_q, b_q, c_q;
  logic [16:0] f_q;
  logic signed [IW-1:0] inner_q;
  logic signed [38:0] plo_q, frlo_q;
  logic signed [S+20:0] phi_q;
  logic signed [S+17:0] frhi_q;
  logic [DVW-1:0] div_q, quo_q;
  logic [1:0] rem_q;

  // Neighbor index resolution.
  logic signed [EW-1:0] ii, sz, ea, ec, ed;
  logic [AW-1:0] ia_d, ic_d, id_d;

  function automatic logic [AW-1:0] clamp_idx(input logic signed [EW-1:0] v,
                                               input logic signed [EW-1:0] n);
    logic signed [EW-1:0] top;
    top = n - EW'(1);
    if (v < 0) begin
      clamp_idx = '0;
    end else if (v > top) begin
      clamp_idx = top[AW-1:0];
    end else begin
      clamp_idx = v[AW-1:0];
    end
  endfunction

  always_comb begin
    ii = $signed({{(EW-AW){1'b0}}, pop_play_idx_i});
    sz = $signed({2'b00, size_i});
    case (cfg_i.edge_mode)
      rwcr_pkg::EdgeConstant: begin
        ea = ii - EW'(1);
        ec = ii + EW'(1);
        ed = ii + EW'(2);
      end
      rwcr_pkg::EdgeMirror: begin
        ea = (ii < EW'(1)) ? EW'(1) : ii - EW'(1);
        ec = (ii + EW'(1) < sz) ? ii + EW'(1) : sz - EW'(1);
        ed = (ii + EW'(2) < sz) ? ii + EW'(2) : (sz <<< 1) - (ii + EW'(3));
      end
      default: begin
        ea = (ii == 0) ? sz - EW'(1) : ii - EW'(1);
        ec = (ii + EW'(1) >= sz) ? ii + EW'(1) - sz : ii + EW'(1);
        ed = (ii + EW'(2) >= sz) ? ii + EW'(2) - sz : ii + EW'(2);
      end
    endcase
    ia_d = clamp_idx(ea, sz);
    ic_d = clamp_idx(ec, sz);
    id_d = clamp_idx(ed, sz);
  end

  // Memory port: clearing pass, record write, then four reads.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = ia_q;
    mem_wdata = entry_q;
    case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_q;
        mem_wdata = '0;
      end
      StWrite: begin
        mem_we   = 1'b1;
        mem_addr = ri_q;
      end
      StRdB:   mem_addr = ib_q;
      StRdC:   mem_addr = ic_q;
      StRdD:   mem_addr = id_q;
      default: mem_addr = ia_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_q <= mem[mem_addr];
  end

  // Cubic datapath.
  logic signed [S+3:0] aa, bb, cc, dd, cb, t1, t2;
  logic signed [S+21:0] t1f;
  logic signed [IW-1:0] inner_d;
  logic [16:0] g;
  logic signed [PW-1:0] p_full;
  logic signed [XW-1:0] xs;
  logic [XW+1:0] xo;
  logic [5:0] cur;
  logic [3:0] qdig;
  logic [1:0] rdig;
  logic signed [XW+1:0] qf;
  logic signed [RFW-1:0] r_full;
  logic signed [RW-1:0] rr;
  logic signed [FW-1:0] frs;
  logic signed [S+6:0] yd;
  logic signed [YW-1:0] yy, yb;
  logic signed [15:0] smooth_code, stepped_code;

  function automatic logic [5:0] div3(input logic [5:0] v);
    logic [5:0] r;
    logic [3:0] q;
    r = v;
    q = '0;
    for (int k = 3; k >= 0; k--) begin
      if (r >= (6'd3 << k)) begin
        r = r - (6'd3 << k);
        q[k] = 1'b1;
      end
    end
    div3 = {q, r[1:0]};
  endfunction

  function automatic logic signed [15:0] to_code(input logic signed [YW-1:0] y,
                                                 input logic [1:0] mode);
    logic signed [CW-1:0] sh, t;
    case (mode)
      rwcr_pkg::RangeBipolar10: begin
        sh = (CW'(y) <<< 16) >>> S;
        t  = sh - CW'(32768);
      end
      rwcr_pkg::RangeBipolar5: begin
        sh = (CW'(y) <<< 15) >>> S;
        t  = sh - CW'(16384);
      end
      default: begin
        sh = (CW'(y) <<< 15) >>> S;
        t  = sh;
      end
    endcase
    if (t < -CW'(32768)) begin
      to_code = 16'sh8000;
    end else if (t > CW'(32767)) begin
      to_code = 16'sh7fff;
    end else begin
      to_code = t[15:0];
    end
  endfunction

  always_comb begin
    aa = $signed({4'b0000, a_q});
    bb = $signed({4'b0000, b_q});
    cc = $signed({4'b0000, c_q});
    dd = $signed({4'b0000, rd_q});
    cb = cc - bb;
    t1 = dd - aa - (cb + (cb <<< 1));
    t2 = dd + (aa <<< 1) - (bb + (bb <<< 1));
    t1f = (S+22)'(t1) * (S+22)'($signed({1'b0, f_q}));
    inner_d = IW'(t1f) + (IW'(t2) <<< 16);
    g = 17'h10000 - f_q;
    p_full = (PW'(phi_q) <<< 20) + PW'(plo_q);
    xs = p_full[PW-1:17];
    // Offset by three times 2^XW so the floor divide works on a positive value.
    xo = {{2{xs[XW-1]}}, xs} + {2'b11, {XW{1'b0}}};
    cur = {rem_q, div_q[DVW-1 -: 4]};
    {qdig, rdig} = div3(cur);
    qf = $signed({1'b0, quo_q[XW:0]}) - $signed({2'b01, {XW{1'b0}}});
    r_full = (RFW'(cb) <<< 16) - RFW'(qf);
    rr = r_full[RW-1:0];
    frs = (FW'(frhi_q) <<< 20) + FW'(frlo_q);
    yd = frs[FW-1:32];
    yb = $signed({8'b0, b_q});
    yy = yb + YW'(yd);
    smooth_code  = to_code(yy, cfg_i.output_range);
    stepped_code = to_code(yb, cfg_i.output_range);
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (pop_valid_i) begin
          rec_q   <= pop_rec_i;
          ri_q    <= pop_rec_idx_i;
          entry_q <= pop_entry_i;
          f_q     <= pop_frac_i;
          ia_q    <= ia_d;
          ib_q    <= pop_play_idx_i;
          ic_q    <= ic_d;
          id_q    <= id_d;
        end
      end
      StRdB:  a_q <= rd_q;
      StRdC:  b_q <= rd_q;
      StRdD:  c_q <= rd_q;
      StMul1: inner_q <= inner_d;
      StMul2: begin
        plo_q <= $signed({1'b0, inner_q[19:0]}) * $signed({1'b0, g});
        phi_q <= (S+21)'($signed(inner_q[IW-1:20])) * (S+21)'($signed({1'b0, g}));
      end
      StSumP: begin
        div_q <= DVW'(xo);
        quo_q <= '0;
        rem_q <= 2'd0;
      end
      StDiv: begin
        div_q <= div_q << 4;
        quo_q <= {quo_q[DVW-5:0], qdig};
        rem_q <= rdig;
      end
      StMulR: begin
        frlo_q <= $signed({1'b0, f_q}) * $signed({1'b0, rr[19:0]});
        frhi_q <= (S+18)'($signed({1'b0, f_q})) * (S+18)'($signed(rr[RW-1:20]));
      end
      default: ;
    endcase
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      rec_out_q   <= 1'b0;
      stepped_q   <= '0;
      smooth_q    <= '0;
    end else begin
      // Drop the result once taken; the finishing state reloads it itself.
      if (out_valid_q && out_ready_i && state_q != StFin) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StClear: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == AW'(TABLE_DEPTH - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (pop_valid_i) begin
            state_q <= pop_rec_i ? StWrite : StRdA;
          end
        end
        StWrite: state_q <= StRdA;
        StRdA:   state_q <= StRdB;
        StRdB:   state_q <= StRdC;
        StRdC:   state_q <= StRdD;
        StRdD:   state_q <= StMul1;
        StMul1:  state_q <= StMul2;
        StMul2:  state_q <= StSumP;
        StSumP: begin
          div_cnt_q <= NCW'(NN - 1);
          state_q   <= StDiv;
        end
        StDiv: begin
          if (div_cnt_q == '0) begin
            state_q <= StMulR;
          end else begin
            div_cnt_q <= div_cnt_q - NCW'(1);
          end
        end
        StMulR: state_q <= StFin;
        StFin: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            stepped_q   <= stepped_code;
            smooth_q    <= smooth_code;
            rec_out_q   <= rec_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign clearing_o         = (state_q == StClear);
  assign pop_ready_o        = (state_q == StIdle);
  assign out_valid_o        = out_valid_q;
  assign stepped_value_o    = stepped_q;
  assign smooth_value_o     = smooth_q;
  assign recording_active_o = rec_out_q;

endmodule

[rtl/recordable_wavetable_cubic_reader_core.sv]
// Top level of the recordable wavetable cubic reader: configuration registers,
// front end, request queue and back end. Depends on rwcr_pkg and the rwcr_* modules.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one request per audio tick:
//   play and record position voltages, the sample to record, the record gate
//   level and the record button. Output channel (out_valid_o / out_ready_i)
//   returns one result per request, in order: stepped value, cubic value and
//   the recording state after that tick.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i);
//   write it only while no request is in flight. Unknown indexes are ignored.
//   The back end handles one request at a time; its pass is set by the single
//   memory port (record write plus four reads) and the divide by three, which
//   retires one nibble per cycle.
//   Throughput: one request per back-end pass while out_ready_i does not hold it.
//   Reset: after rst_ni releases, a clearing pass zeroes the table, one entry
//   per cycle for TABLE_DEPTH cycles; in_ready_o stays low during it, while
//   configuration writes are still taken.
//   Stall: when out_ready_i is low the result holds in the output register,
//   the back end parks on the next finished result and the two-entry queue
//   keeps accepting until it fills.
module recordable_wavetable_cubic_reader_core #(
  parameter int unsigned TABLE_DEPTH = rwcr_pkg::DefTableDepth,
  parameter int unsigned SAMPLE_BITS = rwcr_pkg::DefSampleBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [12:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] play_position_i,
  input  logic signed [15:0] record_position_i,
  input  logic signed [15:0] record_sample_i,
  input  logic signed [15:0] record_gate_level_i,
  input  logic               record_button_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] stepped_value_o,
  output logic signed [15:0] smooth_value_o,
  output logic               recording_active_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned SW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned QW = 1 + AW + SAMPLE_BITS + AW + 17;

  rwcr_pkg::cfg_t cfg_q;
  logic [SW-1:0] size;

  // Configuration registers; the user must let writes land only while idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_range  <= rwcr_pkg::PhaseRangeReset;
      cfg_q.output_range <= rwcr_pkg::OutputRangeReset;
      cfg_q.edge_mode    <= rwcr_pkg::EdgeModeReset;
      cfg_q.record_mode  <= rwcr_pkg::RecordModeReset;
      cfg_q.table_length <= rwcr_pkg::TableLengthReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rwcr_pkg::CfgPhaseRange:  cfg_q.phase_range  <= cfg_wdata_i[1:0];
        rwcr_pkg::CfgOutputRange: cfg_q.output_range <= cfg_wdata_i[1:0];
        rwcr_pkg::CfgEdgeMode:    cfg_q.edge_mode    <= cfg_wdata_i[1:0];
        rwcr_pkg::CfgRecordMode:  cfg_q.record_mode  <= cfg_wdata_i[0];
        rwcr_pkg::CfgTableLength: cfg_q.table_length <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective table size: clamp the programmed length to 4..TABLE_DEPTH.
  always_comb begin
    if (cfg_q.table_length < 13'd4) begin
      size = SW'(4);
    end else if (32'(cfg_q.table_length) > 32'(TABLE_DEPTH)) begin
      size = SW'(TABLE_DEPTH);
    end else begin
      size = SW'(cfg_q.table_length);
    end
  end

  logic clearing;
  logic push_valid, push_ready, pop_valid, pop_ready;
  logic push_rec, pop_rec;
  logic [AW-1:0] push_rec_idx, push_play_idx, pop_rec_idx, pop_play_idx;
  logic [SAMPLE_BITS-1:0] push_entry, pop_entry;
  logic [16:0] push_frac, pop_frac;
  logic [QW-1:0] push_data, pop_data;

  rwcr_front #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .size_i             (size),
    .clearing_i         (clearing),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .play_position_i    (play_position_i),
    .record_position_i  (record_position_i),
    .record_sample_i    (record_sample_i),
    .record_gate_level_i(record_gate_level_i),
    .record_button_i    (record_button_i),
    .push_valid_o       (push_valid),
    .push_ready_i       (push_ready),
    .push_rec_o         (push_rec),
    .push_rec_idx_o     (push_rec_idx),
    .push_entry_o       (push_entry),
    .push_play_idx_o    (push_play_idx),
    .push_frac_o        (push_frac)
  );

  assign push_data = {push_rec, push_rec_idx, push_entry, push_play_idx, push_frac};
  assign {pop_rec, pop_rec_idx, pop_entry, pop_play_idx, pop_frac} = pop_data;

  rwcr_queue #(
    .W(QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  rwcr_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .size_i            (size),
    .clearing_o        (clearing),
    .pop_valid_i       (pop_valid),
    .pop_ready_o       (pop_ready),
    .pop_rec_i         (pop_rec),
    .pop_rec_idx_i     (pop_rec_idx),
    .pop_entry_i       (pop_entry),
    .pop_play_idx_i    (pop_play_idx),
    .pop_frac_i        (pop_frac),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .stepped_value_o   (stepped_value_o),
    .smooth_value_o    (smooth_value_o),
    .recording_active_o(recording_active_o)
  );

endmodule

[rtl/rwcr_checker.sv]
// Port-level checks for the recordable wavetable cubic reader, bound to the top level.
// Depends on recordable_wavetable_cubic_reader_core.
module rwcr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] stepped_value_o,
  input logic signed [15:0] smooth_value_o,
  input logic               recording_active_o
);

  // Requests accepted but not yet delivered.
  logic [2:0] pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_q + 3'(in_valid_i & in_ready_o) - 3'(out_valid_o & out_ready_i);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(stepped_value_o)
      && $stable(smooth_value_o) && $stable(recording_active_o))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("result without a pending request");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> pend_q <= 3'd3)
    else $error("ready with buffers full");

  a_clear_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_o && !out_valid_o)
    else $error("busy state wrong right after reset");

endmodule

bind recordable_wavetable_cubic_reader_core rwcr_checker u_rwcr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .stepped_value_o   (stepped_value_o),
  .smooth_value_o    (smooth_value_o),
  .recording_active_o(recording_active_o)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for recordable_wavetable_cubic_reader_core: a cycle-free model of the
// wavetable (record, hysteresis, cubic read) predicts every result. Needs rwcr_pkg and the RTL.
module tb;

  localparam int          TblDepth   = 4096;
  localparam int          IdleLimit  = 9000;  // covers the clearing pass after reset
  localparam logic [1:0]  RangeSpare = 2'd3;
  localparam logic [1:0]  EdgeSpare  = 2'd3;
  localparam logic [2:0]  CfgIdxVoid = 3'd5;  // first unused register index
  localparam logic [2:0]  CfgIdxTop  = 3'd7;  // last unused register index

  typedef struct packed {
    logic signed [15:0] stepped;
    logic signed [15:0] smooth;
    logic               rec;
  } wave_out_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [12:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] play_position_i = '0;
  logic signed [15:0] record_position_i = '0;
  logic signed [15:0] record_sample_i = '0;
  logic signed [15:0] record_gate_level_i = '0;
  logic               record_button_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] stepped_value_o;
  logic signed [15:0] smooth_value_o;
  logic               recording_active_o;

  recordable_wavetable_cubic_reader_core u_dut (.*);

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Model state: table contents, qualifiers and the register file
  logic [15:0] wave_mem [TblDepth];
  logic        rec_on, gate_hi, btn_hi;
  logic [1:0]  m_phase_rng, m_out_rng, m_edge;
  logic        m_rec_mode;
  logic [12:0] m_len;

  wave_out_t   pending_out[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;  // stretch with no idling on either side

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  // Voltage code onto a 0..65536 position under a range mode
  function automatic longint volt_to_pos(logic signed [15:0] x, logic [1:0] mode);
    longint v;
    v = longint'(x);
    if (mode == rwcr_pkg::RangeBipolar10) return clampl(v + 32768, 0, 65536);
    if (mode == rwcr_pkg::RangeBipolar5) return clampl(2 * v + 32768, 0, 65536);
    return clampl(2 * v, 0, 65536);
  endfunction

  function automatic logic [15:0] entry_to_volt(longint y);
    longint t;
    if (m_out_rng == rwcr_pkg::RangeBipolar10) t = fdiv(y * 65536, 65536) - 32768;
    else if (m_out_rng == rwcr_pkg::RangeBipolar5) t = fdiv(y * 32768, 65536) - 16384;
    else t = fdiv(y * 32768, 65536);
    return 16'(clampl(t, -32768, 32767));
  endfunction

  // One audio tick: qualify, record, then read stepped and cubic values
  function automatic wave_out_t tick_wave(logic signed [15:0] play, logic signed [15:0] rpos,
                                          logic signed [15:0] samp, logic signed [15:0] gate,
                                          logic btn);
    longint size, rp, ri, p, i, f, ia, ic, id, a, b, c, d, inner, pp, r, y;
    logic lvl, g_rise, b_rise;
    wave_out_t res;
    size = clampl(longint'(m_len), 4, TblDepth);
    lvl = gate_hi;
    if (gate >= rwcr_pkg::GateOnCode) lvl = 1'b1;
    else if (gate <= rwcr_pkg::GateOffCode) lvl = 1'b0;
    g_rise = !gate_hi && lvl;
    b_rise = !btn_hi && btn;
    gate_hi = lvl;
    btn_hi = btn;
    if (m_rec_mode == rwcr_pkg::RecordGate) rec_on = gate_hi | btn_hi;
    else if (g_rise || b_rise) rec_on = ~rec_on;

    rp = volt_to_pos(rpos, m_phase_rng);
    ri = clampl((rp * size) >>> 16, 0, size - 1);
    if (rec_on) wave_mem[ri] = 16'(clampl(volt_to_pos(samp, m_out_rng), 0, 65535));

    p = volt_to_pos(play, m_phase_rng);
    i = clampl((p * size) >>> 16, 0, size - 1);
    f = p * size - i * 65536;
    if (m_edge == rwcr_pkg::EdgeConstant) begin
      ia = clampl(i - 1, 0, size - 1);
      ic = clampl(i + 1, 0, size - 1);
      id = clampl(i + 2, 0, size - 1);
    end else if (m_edge == rwcr_pkg::EdgeMirror) begin
      ia = i < 1 ? 1 : i - 1;
      ic = i + 1 < size ? i + 1 : size - 1;
      id = i + 2 < size ? i + 2 : 2 * size - (i + 3);
    end else begin
      ia = i == 0 ? size - 1 : i - 1;
      ic = i + 1 >= size ? i + 1 - size : i + 1;
      id = i + 2 >= size ? i + 2 - size : i + 2;
    end
    a = wave_mem[clampl(ia, 0, size - 1)];
    b = wave_mem[i];
    c = wave_mem[clampl(ic, 0, size - 1)];
    d = wave_mem[clampl(id, 0, size - 1)];
    inner = (d - a - 3 * (c - b)) * f + (d + 2 * a - 3 * b) * 65536;
    pp = inner * (65536 - f);
    r = (c - b) * 65536 - fdiv(pp, 393216);
    y = b + fdiv(f * r, longint'(1) << 32);
    res.stepped = entry_to_volt(b);
    res.smooth = entry_to_volt(y);
    res.rec = rec_on;
    return res;
  endfunction

  // Activity watchdog: any accepted request, result or register write resets it
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Compare every delivered result with the oldest prediction
  always @(posedge clk_i) begin
    wave_out_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d/%0d/%0d",
                                       stepped_value_o, smooth_value_o, recording_active_o);
      end else begin
        want = pending_out.pop_front();
        if (want.stepped !== stepped_value_o || want.smooth !== smooth_value_o ||
            want.rec !== recording_active_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: stepped %0d/%0d smooth %0d/%0d rec %0d/%0d (exp/got)",
                     want.stepped, stepped_value_o, want.smooth, smooth_value_o,
                     want.rec, recording_active_o);
        end
      end
    end
  end

  // Result side: stall a random number of cycles before each result
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Send one request, holding the payload until it is taken, and predict it
  task automatic send_req(logic signed [15:0] play, logic signed [15:0] rpos,
                          logic signed [15:0] samp, logic signed [15:0] gate, logic btn);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    play_position_i = play;
    record_position_i = rpos;
    record_sample_i = samp;
    record_gate_level_i = gate;
    record_button_i = btn;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_out.insert(pending_out.size(), tick_wave(play, rpos, samp, gate, btn));
    @(negedge clk_i);
  endtask

  // Drain, then write one register; the model follows the same masking
  task automatic write_reg(logic [2:0] idx, logic [12:0] val);
    in_valid_i = 1'b0;
    while (pending_out.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      rwcr_pkg::CfgPhaseRange:  m_phase_rng = val[1:0];
      rwcr_pkg::CfgOutputRange: m_out_rng = val[1:0];
      rwcr_pkg::CfgEdgeMode:    m_edge = val[1:0];
      rwcr_pkg::CfgRecordMode:  m_rec_mode = val[0];
      rwcr_pkg::CfgTableLength: m_len = val;
      default: ;
    endcase
  endtask

  task automatic set_all(logic [1:0] ph, logic [1:0] orng, logic [1:0] edg, logic rm,
                         logic [12:0] len);
    write_reg(rwcr_pkg::CfgPhaseRange, 13'(ph));
    write_reg(rwcr_pkg::CfgOutputRange, 13'(orng));
    write_reg(rwcr_pkg::CfgEdgeMode, 13'(edg));
    write_reg(rwcr_pkg::CfgRecordMode, 13'(rm));
    write_reg(rwcr_pkg::CfgTableLength, len);
  endtask

  function automatic logic signed [15:0] pick_gate();
    case ($urandom_range(0, 5))
      0: return 16'sd6554;
      1: return 16'sd6553;
      2: return 16'sd327;
      3: return 16'sd328;
      4: return 16'($urandom_range(0, 8000));
      default: return 16'($urandom);
    endcase
  endfunction

  // Reset defaults, field extremes and the unused register indexes
  task automatic test_extremes();
    send_req(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
    send_req(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    send_req(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
    send_req(16'shffff, 16'sh5555, 16'shaaaa, 16'sh0000, 1'b0);
    write_reg(CfgIdxVoid, 13'h1fff);
    write_reg(CfgIdxTop, 13'h0000);
    send_req(16'sh1234, 16'sh4321, 16'sh7fff, 16'sh0000, 1'b1);
  endtask

  // Gate hysteresis thresholds, then toggle recording on rising edges
  task automatic test_gate_and_toggle();
    send_req(16'sd100, 16'sd100, 16'sd9000, 16'sd6553, 1'b0);
    send_req(16'sd100, 16'sd100, 16'sd9000, 16'sd6554, 1'b0);
    send_req(16'sd100, 16'sd200, 16'sd5000, 16'sd328, 1'b0);
    send_req(16'sd100, 16'sd300, 16'sd5000, 16'sd327, 1'b0);
    write_reg(rwcr_pkg::CfgRecordMode, 13'(rwcr_pkg::RecordToggle));
    send_req(16'sd0, 16'sd1000, 16'sd2000, 16'sd7000, 1'b0);
    send_req(16'sd0, 16'sd2000, 16'sd3000, 16'sd7000, 1'b1);
    send_req(16'sd0, 16'sd3000, 16'sd4000, 16'sd0, 1'b0);
    send_req(16'sd0, 16'sd3000, 16'sd4000, 16'sd7000, 1'b1);
    write_reg(rwcr_pkg::CfgRecordMode, 13'(rwcr_pkg::RecordGate));
  endtask

  // Every range and edge mode incl. spare codes, and table lengths inside, at and outside 4..4096
  task automatic test_modes_and_lengths();
    logic [12:0] lens[6] = '{13'd0, 13'd3, 13'd4, 13'd4096, 13'd8191, 13'd5};
    for (int k = 0; k < 6; k++) begin
      set_all(2'(k % 4), 2'((k + 1) % 4), 2'(k % 4), 1'b0, lens[k]);
      send_req(16'sh7fff, 16'sh7fff, 16'($urandom), 16'sh7fff, 1'b0);  // record index overrun
      send_req(16'sh8000, 16'sh4000, 16'($urandom), 16'sh7fff, 1'b0);
      send_req(16'($urandom), 16'($urandom), 16'($urandom), 16'sh0000, 1'b0);
    end
  endtask

  // Random phases over varied settings; most ticks record at random places
  task automatic test_random();
    logic [12:0] len;
    for (int ph = 0; ph < 9; ph++) begin
      if ($urandom_range(0, 3) == 0) len = 13'($urandom);
      else if ($urandom_range(0, 4) == 0) len = 13'd4096;
      else len = 13'($urandom_range(4, 40));
      set_all(2'($urandom), 2'($urandom), 2'($urandom), 1'($urandom), len);
      for (int n = 0; n < 90; n++) begin
        if (n % 30 == 0) calm = ($urandom_range(0, 3) == 0);
        send_req(16'($urandom), 16'($urandom), 16'($urandom), pick_gate(),
                 1'($urandom_range(0, 3) == 0));
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    foreach (wave_mem[k]) wave_mem[k] = '0;
    rec_on = 1'b0;
    gate_hi = 1'b0;
    btn_hi = 1'b0;
    m_phase_rng = rwcr_pkg::PhaseRangeReset;
    m_out_rng = rwcr_pkg::OutputRangeReset;
    m_edge = rwcr_pkg::EdgeModeReset;
    m_rec_mode = rwcr_pkg::RecordModeReset;
    m_len = rwcr_pkg::TableLengthReset;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_extremes();
    test_gate_and_toggle();
    test_modes_and_lengths();
    set_all(rwcr_pkg::RangeUnipolar10, rwcr_pkg::RangeBipolar10, EdgeSpare,
            rwcr_pkg::RecordGate, 13'd10);
    set_all(RangeSpare, RangeSpare, rwcr_pkg::EdgeMirror, rwcr_pkg::RecordGate, 13'd10);
    test_random();

    in_valid_i = 1'b0;
    while (pending_out.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
